@@ sv/tre_pkg.sv @@
// types, codes and constants shared by the threshold rule event engine
`timescale 1ns / 1ps

package tre_pkg;

    localparam int NUM_RULES   = 16;
    localparam int MAX_ACTIONS = 4;

    localparam int RESULT_CAP = 64;
    localparam int CAP_W      = 7;
    localparam int ACT_W      = 5;

    localparam logic REQ_EVAL  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic KIND_BOOL = 1'b0;
    localparam logic KIND_INT  = 1'b1;

    localparam logic [1:0] CFG_EVT_LIMIT    = 2'd0;
    localparam logic [1:0] CFG_ACTIVE_RULES = 2'd1;

    localparam logic [2:0] CMP_EQ  = 3'd0;
    localparam logic [2:0] CMP_NE  = 3'd1;
    localparam logic [2:0] CMP_GT  = 3'd2;
    localparam logic [2:0] CMP_GTE = 3'd3;
    localparam logic [2:0] CMP_LT  = 3'd4;
    localparam logic [2:0] CMP_LTE = 3'd5;

    typedef struct packed {
        logic               req_type;
        logic [3:0]         rule_slot;
        logic               rule_enable;
        logic [7:0]         source_code;
        logic [7:0]         key_code;
        logic [2:0]         comparator;
        logic               value_kind;
        logic signed [31:0] operand_value;
        logic [31:0]        sustain_time;
        logic [31:0]        cooldown_time;
        logic [2:0]         actions_per_fire;
        logic [31:0]        now_ms;
    } t_req;

    typedef struct packed {
        logic [31:0]        event_sequence;
        logic [31:0]        event_time;
        logic [3:0]         fired_slot;
        logic [1:0]         action_slot;
        logic [7:0]         event_source;
        logic               measured_kind;
        logic signed [31:0] meas_value;
        logic [31:0]        fires_so_far;
        logic               last_of_run;
    } t_result;

    typedef struct packed {
        logic               enable;
        logic [7:0]         source;
        logic [7:0]         key;
        logic [2:0]         cmp;
        logic               kind;
        logic signed [31:0] threshold;
        logic [31:0]        sustain;
        logic [31:0]        cooldown;
        logic [ACT_W-1:0]   actions;
    } t_rule;

    typedef struct packed {
        logic        cond_true;
        logic        fired_in_period;
        logic [31:0] true_since;
        logic        has_fired;
        logic [31:0] last_fire_time;
        logic [31:0] fire_counter;
    } t_rstate;

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_CMPV,
        S_SUSTD,
        S_SUSTC,
        S_COOLD,
        S_COOLC,
        S_CAP,
        S_EMIT,
        S_WB,
        S_NEXT,
        S_DONE
    } t_fsm;

endpackage

@@ sv/tre_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ sv/tre_alu.sv @@
// shared 33-bit subtract and compare unit
`timescale 1ns / 1ps

module tre_alu (
    input  logic        i_signed,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [31:0] o_diff,
    output logic        o_eq,
    output logic        o_lt
);

    logic [32:0] w_a;
    logic [32:0] w_b;
    logic [32:0] w_sub;

    assign w_a    = {i_signed & i_a[31], i_a};
    assign w_b    = {i_signed & i_b[31], i_b};
    assign w_sub  = w_a - w_b;
    assign o_diff = w_sub[31:0];
    assign o_eq   = (w_sub == 33'd0);
    assign o_lt   = w_sub[32];

endmodule

@@ sv/threshold_rule_event_engine_top.sv @@
// top level of the threshold rule event engine: sequencer and datapath
`timescale 1ns / 1ps

// A rule write (req_type 1) is taken in its accept cycle and busy stays low. An
// evaluate request walks rule slots in order on one shared subtract/compare unit:
// each walked slot is read, loaded and compared; a slot that does not match goes on
// to the next, one whose condition is false writes its state back, and one tested
// further goes through sustain and, if it has fired before, cooldown checks and may
// emit events before its state is written back. busy is high meanwhile.
// Results leave on o_strobe and cannot be held off by the receiver; the last one
// of a fact comes out in the first cycle with busy low. Configuration writes are
// always ready.
module threshold_rule_event_engine_top
    import tre_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_strobe,
    output t_result    o_result,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data
);

    localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
    localparam int CNT_W = $clog2(NUM_RULES + 1);

    t_fsm r_state, n_state;

    logic [CAP_W-1:0] r_evt_limit;
    logic [4:0]       r_active_rules;

    logic [CAP_W-1:0] r_cap;
    logic [CNT_W-1:0] r_rules;
    logic [CAP_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [ACT_W-1:0] r_act;
    logic [31:0]      r_seq;
    logic [31:0]      r_diff;
    logic [NUM_RULES-1:0] r_valid;

    logic [7:0]         r_f_source;
    logic [7:0]         r_f_key;
    logic               r_f_kind;
    logic signed [31:0] r_f_value;
    logic [31:0]        r_f_now;

    t_rule   r_rule;
    t_rstate r_st;
    t_result r_pend;
    logic    r_pend_v;
    t_result r_out;
    logic    r_strobe;

    t_rule   w_rule_q;
    t_rstate w_st_q;
    t_rule   w_rule_wr;
    logic    w_rule_we;
    logic    w_st_we;
    logic [IDX_W-1:0] w_wr_slot;

    logic        w_alu_signed;
    logic [31:0] w_alu_a, w_alu_b, w_alu_diff;
    logic        w_alu_eq, w_alu_lt;

    logic w_accept, w_match, w_cmp_ok, w_last_act, w_walk_end, w_short;
    logic [CAP_W-1:0] w_cap;
    logic [CNT_W-1:0] w_rules;
    logic [2:0]       w_acts_in;
    t_result          w_event;
    t_result          w_last_ev;

    assign w_accept   = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign w_wr_slot  = IDX_W'(i_req.rule_slot);
    assign w_acts_in  = i_req.actions_per_fire;

    assign w_cap   = (r_evt_limit > CAP_W'(RESULT_CAP)) ? CAP_W'(RESULT_CAP) : r_evt_limit;
    assign w_rules = (32'(r_active_rules) > NUM_RULES) ? CNT_W'(NUM_RULES)
                                                       : CNT_W'(r_active_rules);

    always_comb begin
        w_rule_wr.enable    = i_req.rule_enable;
        w_rule_wr.source    = i_req.source_code;
        w_rule_wr.key       = i_req.key_code;
        w_rule_wr.cmp       = i_req.comparator;
        w_rule_wr.kind      = i_req.value_kind;
        w_rule_wr.threshold = (i_req.value_kind == KIND_BOOL)
                              ? ((i_req.operand_value != 32'sd0) ? 32'sd1 : 32'sd0)
                              : i_req.operand_value;
        w_rule_wr.sustain   = i_req.sustain_time;
        w_rule_wr.cooldown  = i_req.cooldown_time;
        w_rule_wr.actions   = (32'(w_acts_in) > MAX_ACTIONS) ? ACT_W'(MAX_ACTIONS)
                                                              : ACT_W'(w_acts_in);
    end

    tre_ram #(.WIDTH($bits(t_rule)), .DEPTH(NUM_RULES), .AW(IDX_W)) u_rule_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_rule_we),
        .i_wr_addr (w_wr_slot),
        .i_wr_data (w_rule_wr),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rule_q)
    );

    tre_ram #(.WIDTH($bits(t_rstate)), .DEPTH(NUM_RULES), .AW(IDX_W)) u_state_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_st_we),
        .i_wr_addr (r_idx),
        .i_wr_data (r_st),
        .i_rd_addr (r_idx),
        .o_rd_data (w_st_q)
    );

    tre_alu u_alu (
        .i_signed (w_alu_signed),
        .i_a      (w_alu_a),
        .i_b      (w_alu_b),
        .o_diff   (w_alu_diff),
        .o_eq     (w_alu_eq),
        .o_lt     (w_alu_lt)
    );

    always_comb begin
        w_alu_signed = 1'b0;
        w_alu_a      = 32'd0;
        w_alu_b      = 32'd0;
        case (r_state)
            S_CMPV: begin
                w_alu_signed = 1'b1;
                w_alu_a      = r_f_value;
                w_alu_b      = r_rule.threshold;
            end
            S_SUSTD: begin
                w_alu_a = r_f_now;
                w_alu_b = r_st.true_since;
            end
            S_SUSTC: begin
                w_alu_a = r_diff;
                w_alu_b = r_rule.sustain;
            end
            S_COOLD: begin
                w_alu_a = r_f_now;
                w_alu_b = r_st.last_fire_time;
            end
            S_COOLC: begin
                w_alu_a = r_diff;
                w_alu_b = r_rule.cooldown;
            end
            default: begin
                w_alu_signed = 1'b0;
            end
        endcase
    end

    assign w_match = r_rule.enable && (r_rule.source == r_f_source)
                     && ((r_rule.key == 8'd0) || (r_rule.key == r_f_key));

    always_comb begin
        w_cmp_ok = 1'b0;
        if (r_f_kind == r_rule.kind) begin
            case (r_rule.cmp)
                CMP_EQ:  w_cmp_ok = w_alu_eq;
                CMP_NE:  w_cmp_ok = !w_alu_eq;
                CMP_GT:  w_cmp_ok = (r_f_kind == KIND_INT) && !w_alu_lt && !w_alu_eq;
                CMP_GTE: w_cmp_ok = (r_f_kind == KIND_INT) && !w_alu_lt;
                CMP_LT:  w_cmp_ok = (r_f_kind == KIND_INT) && w_alu_lt;
                CMP_LTE: w_cmp_ok = (r_f_kind == KIND_INT) && (w_alu_lt || w_alu_eq);
                default: w_cmp_ok = 1'b0;
            endcase
        end
    end

    assign w_short    = (r_cap - r_count) < CAP_W'(r_rule.actions);
    assign w_last_act = (r_act + ACT_W'(1)) == r_rule.actions;
    assign w_walk_end = ((CNT_W'(r_idx) + CNT_W'(1)) >= r_rules) || (r_count >= r_cap);

    always_comb begin
        w_event.event_sequence = r_seq;
        w_event.event_time     = r_f_now;
        w_event.fired_slot     = 4'(r_idx);
        w_event.action_slot    = 2'(r_act);
        w_event.event_source   = r_f_source;
        w_event.measured_kind  = r_f_kind;
        w_event.meas_value     = r_f_value;
        w_event.fires_so_far   = r_st.fire_counter;
        w_event.last_of_run    = 1'b0;
    end

    always_comb begin
        w_last_ev             = r_pend;
        w_last_ev.last_of_run = 1'b1;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && (i_req.req_type == REQ_EVAL)) begin
                    n_state = ((w_cap == '0) || (w_rules == '0)) ? S_DONE : S_READ;
                end
            end
            S_READ:  n_state = S_LOAD;
            S_LOAD:  n_state = S_CMPV;
            S_CMPV: begin
                if (!w_match) begin
                    n_state = S_NEXT;
                end else if (!w_cmp_ok) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_SUSTD;
                end
            end
            S_SUSTD: n_state = S_SUSTC;
            S_SUSTC: begin
                if (w_alu_lt || r_st.fired_in_period) begin
                    n_state = S_WB;
                end else if (r_st.has_fired) begin
                    n_state = S_COOLD;
                end else begin
                    n_state = S_CAP;
                end
            end
            S_COOLD: n_state = S_COOLC;
            S_COOLC: n_state = w_alu_lt ? S_WB : S_CAP;
            S_CAP: begin
                if (w_short || (r_rule.actions == '0)) begin
                    n_state = S_WB;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT:  n_state = w_last_act ? S_WB : S_EMIT;
            S_WB:    n_state = S_NEXT;
            S_NEXT:  n_state = w_walk_end ? S_DONE : S_READ;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        busy      = (r_state != S_IDLE);
        w_rule_we = 1'b0;
        w_st_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_rule_we = w_accept && (i_req.req_type == REQ_WRITE)
                            && (32'(i_req.rule_slot) < NUM_RULES);
            end
            S_WB:    w_st_we = 1'b1;
            default: w_st_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_evt_limit    <= CAP_W'(16);
            r_active_rules <= 5'd0;
            r_seq          <= 32'd1;
            r_valid        <= '0;
            r_pend_v       <= 1'b0;
            r_strobe       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= r_pend_v && ((r_state == S_EMIT) || (r_state == S_DONE));
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_EVT_LIMIT:    r_evt_limit    <= i_cfg_data;
                    CFG_ACTIVE_RULES: r_active_rules <= i_cfg_data[4:0];
                    default:          r_evt_limit    <= r_evt_limit;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_rule_we) begin
                        r_valid[w_wr_slot] <= 1'b0;
                    end
                end
                S_WB: begin
                    r_valid[r_idx] <= 1'b1;
                end
                S_EMIT: begin
                    r_seq    <= r_seq + 32'd1;
                    r_pend_v <= 1'b1;
                end
                S_DONE: begin
                    r_pend_v <= 1'b0;
                end
                default: begin
                    r_pend_v <= r_pend_v;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_idx      <= '0;
                r_count    <= '0;
                r_cap      <= w_cap;
                r_rules    <= w_rules;
                r_f_source <= i_req.source_code;
                r_f_key    <= i_req.key_code;
                r_f_kind   <= i_req.value_kind;
                r_f_now    <= i_req.now_ms;
                r_f_value  <= (i_req.value_kind == KIND_BOOL)
                              ? ((i_req.operand_value != 32'sd0) ? 32'sd1 : 32'sd0)
                              : i_req.operand_value;
            end
            S_LOAD: begin
                r_rule <= w_rule_q;
                r_st   <= r_valid[r_idx] ? w_st_q : '0;
            end
            S_CMPV: begin
                if (!w_cmp_ok) begin
                    r_st.cond_true       <= 1'b0;
                    r_st.fired_in_period <= 1'b0;
                    r_st.true_since      <= 32'd0;
                end else if (!r_st.cond_true) begin
                    r_st.cond_true       <= 1'b1;
                    r_st.fired_in_period <= 1'b0;
                    r_st.true_since      <= r_f_now;
                end
            end
            S_SUSTD, S_COOLD: begin
                r_diff <= w_alu_diff;
            end
            S_CAP: begin
                r_act <= '0;
                if (!w_short) begin
                    r_st.fired_in_period <= 1'b1;
                    r_st.has_fired       <= 1'b1;
                    r_st.last_fire_time  <= r_f_now;
                    r_st.fire_counter    <= r_st.fire_counter + 32'd1;
                end
            end
            S_EMIT: begin
                r_act   <= r_act + ACT_W'(1);
                r_count <= r_count + CAP_W'(1);
                r_pend  <= w_event;
                if (r_pend_v) begin
                    r_out <= r_pend;
                end
            end
            S_NEXT: begin
                r_idx <= r_idx + IDX_W'(1);
            end
            S_DONE: begin
                r_out <= w_last_ev;
            end
            default: begin
                r_diff <= r_diff;
            end
        endcase
    end

    assign o_strobe = r_strobe;
    assign o_result = r_out;

endmodule

@@ sv/tre_checker.sv @@
// port level checker for the threshold rule event engine, bound to the top
`timescale 1ns / 1ps

module tre_checker
    import tre_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_req    i_req,
    input logic    o_strobe,
    input t_result o_result,
    input logic    o_cfg_ready
);

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !busy)
        else $error("busy after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == REQ_EVAL) |=> busy)
        else $error("transaction accepted but not busy");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last_of_run |-> busy)
        else $error("non-final event while idle");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_of_run |=> !o_strobe)
        else $error("event right after last of run");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind threshold_rule_event_engine_top tre_checker u_tre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req       (i_req),
    .o_strobe    (o_strobe),
    .o_result    (o_result),
    .o_cfg_ready (o_cfg_ready)
);
